>>> rtl/scmb_pkg.sv
// Shared types and constants for the Sankoff parent score combiner.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
`timescale 1ns / 1ps

package scmb_pkg;

   // Four nucleotide lanes (A, C, G, T), 16-bit unsigned scores
   localparam int NUC_COUNT = 4;
   localparam int SCORE_W   = 16;

   typedef logic [SCORE_W-1:0]                nuc_score_type;
   typedef logic [NUC_COUNT-1:0][SCORE_W-1:0] score_vec_type;
   typedef logic [NUC_COUNT-1:0]              nuc_mask_type;

   // Saturation ceiling for every accumulator
   localparam nuc_score_type SCORE_MAX = '1;

   // Stream widths
   localparam int REQ_DATA_W = 2 * NUC_COUNT * SCORE_W;
   localparam int RSP_DATA_W = NUC_COUNT * SCORE_W;

   // Shared control from the top level to the accumulator lanes
   typedef struct packed {
      logic take;    // a request leaves the min stage into the lanes
      logic child;   // request carries a child's scores
      logic last;    // final request of the node: report and clear
   } lane_ctrl_type;

endpackage

>>> rtl/scmb_min_unit.sv
// Min stage: minimum of one child's four scores and the mask of lanes above it.
// Depends on scmb_pkg.
`timescale 1ns / 1ps

module scmb_min_unit (
   input  logic                    clock,
   input  logic                    load,
   input  scmb_pkg::score_vec_type child_score,
   output scmb_pkg::nuc_score_type best,
   output scmb_pkg::nuc_mask_type  not_tied
);

   scmb_pkg::nuc_score_type lo_ac;
   scmb_pkg::nuc_score_type lo_gt;
   scmb_pkg::nuc_score_type best_in;
   scmb_pkg::nuc_mask_type  not_tied_in;
   scmb_pkg::nuc_score_type best_ff;
   scmb_pkg::nuc_mask_type  not_tied_ff;

   // Two-level compare tree, then per-lane equality against the minimum
   always_comb begin
      lo_ac   = (child_score[0] < child_score[1]) ? child_score[0] : child_score[1];
      lo_gt   = (child_score[2] < child_score[3]) ? child_score[2] : child_score[3];
      best_in = (lo_ac < lo_gt) ? lo_ac : lo_gt;
      for (int k = 0; k < scmb_pkg::NUC_COUNT; k++) begin
         not_tied_in[k] = (child_score[k] != best_in);
      end
   end

   // Payload register, loaded on each accepted request
   always_ff @(posedge clock) begin
      if (load) begin
         best_ff     <= best_in;
         not_tied_ff <= not_tied_in;
      end
   end

   assign best     = best_ff;
   assign not_tied = not_tied_ff;

endmodule

>>> rtl/scmb_lane.sv
// One accumulator lane: saturating running sum for one parent nucleotide.
// Depends on scmb_pkg; instantiated once per nucleotide by the top level.
`timescale 1ns / 1ps

module scmb_lane (
   input  logic                    clock,
   input  logic                    reset,
   input  scmb_pkg::lane_ctrl_type ctrl,
   input  scmb_pkg::nuc_score_type best,
   input  logic                    not_tied,
   input  scmb_pkg::nuc_score_type old_score,
   output scmb_pkg::nuc_score_type res_sum,
   output logic                    res_diff
);

   scmb_pkg::nuc_score_type    sum_ff;
   scmb_pkg::nuc_score_type    sum_in;
   scmb_pkg::nuc_score_type    acc_next;
   logic [scmb_pkg::SCORE_W:0] addend;
   logic [scmb_pkg::SCORE_W:0] total;
   scmb_pkg::nuc_score_type    res_sum_ff;
   logic                       res_diff_ff;

   // best + substitution penalty, added with saturation
   always_comb begin
      addend   = {1'b0, best} + {{scmb_pkg::SCORE_W{1'b0}}, not_tied};
      total    = {1'b0, sum_ff} + addend;
      acc_next = sum_ff;
      if (ctrl.child) begin
         acc_next = total[scmb_pkg::SCORE_W] ? scmb_pkg::SCORE_MAX
                                              : total[scmb_pkg::SCORE_W-1:0];
      end
      sum_in = ctrl.last ? '0 : acc_next;
   end

   // Accumulator: cleared by reset and after each node's last request
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (ctrl.take) begin
         sum_ff <= sum_in;
      end
   end

   // Final sum and mismatch against the old score
   always_ff @(posedge clock) begin
      if (ctrl.take && ctrl.last) begin
         res_sum_ff  <= acc_next;
         res_diff_ff <= (acc_next != old_score);
      end
   end

   assign res_sum  = res_sum_ff;
   assign res_diff = res_diff_ff;

endmodule

>>> rtl/scmb_merge.sv
// Merge stage: folds the lanes' mismatch bits into one flag and holds the result.
// Depends on scmb_pkg; drives the response stream of the top level.
`timescale 1ns / 1ps

module scmb_merge (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  scmb_pkg::score_vec_type lane_sum,
   input  scmb_pkg::nuc_mask_type  lane_diff,
   output logic                    out_valid,
   input  logic                    out_ready,
   output scmb_pkg::score_vec_type out_sum,
   output logic                    out_changed
);

   logic                    out_valid_ff;
   scmb_pkg::score_vec_type out_sum_ff;
   logic                    out_changed_ff;

   // Slot free when empty or being drained this cycle
   assign in_ready = !out_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (in_ready) begin
         out_valid_ff <= in_valid;
      end
   end

   // Result register: OR of lane mismatches
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         out_sum_ff     <= lane_sum;
         out_changed_ff <= |lane_diff;
      end
   end

   assign out_valid   = out_valid_ff;
   assign out_sum     = out_sum_ff;
   assign out_changed = out_changed_ff;

endmodule

>>> rtl/sankoff_parent_score_combine_core.sv
// Top level of the Sankoff parent score combiner: min stage, four lanes, merge.
// Depends on scmb_pkg, scmb_min_unit, scmb_lane and scmb_merge.
//
//  channel | dir | tvalid/tready | tdata                          | tuser        | tlast
//  req_    | in  | yes           | child_score a,c,g,t; old a,c,g,t | child_valid  | last_child
//  rsp_    | out | yes           | node_score a,c,g,t             | changed flag | -
//
// One request per cycle while rsp_tready keeps up; the lane accumulators add once per cycle.
// A last request reaches rsp_tvalid through the min stage, the lane result
// and the output register, in that order.
// Synchronous active-high reset clears all valid flags and the accumulators.
// Each stage holds while the next is full, so req_tready drops only when the
// min stage, the lane result and the output register are all occupied and
// rsp_tready is low.
`timescale 1ns / 1ps

module sankoff_parent_score_combine_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // child_score_a, _c, _g, _t, old_score_a, _c, _g, _t (16 bits each, low first)
   input  logic [scmb_pkg::REQ_DATA_W-1:0]   req_tdata,
   // child_valid
   input  logic                              req_tuser,
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // node_score_a, _c, _g, _t (16 bits each, low first)
   output logic [scmb_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // changed flag: any node score differs from its old score
   output logic                              rsp_tuser
);

   localparam int OLD_LSB = scmb_pkg::NUC_COUNT * scmb_pkg::SCORE_W;

   scmb_pkg::score_vec_type child_score;
   scmb_pkg::score_vec_type old_in;
   scmb_pkg::score_vec_type old_ff;
   logic                    child_ff;
   logic                    last_ff;
   logic                    a_valid_ff;
   logic                    res_valid_ff;
   logic                    a_ready;
   logic                    lane_ready;
   logic                    lane_take;
   logic                    req_take;
   logic                    merge_ready;
   scmb_pkg::nuc_score_type best;
   scmb_pkg::nuc_mask_type  not_tied;
   scmb_pkg::score_vec_type lane_sum;
   scmb_pkg::nuc_mask_type  lane_diff;
   scmb_pkg::score_vec_type out_sum;
   scmb_pkg::lane_ctrl_type lane_ctrl;

   // Request unpacking
   always_comb begin
      for (int k = 0; k < scmb_pkg::NUC_COUNT; k++) begin
         child_score[k] = req_tdata[k*scmb_pkg::SCORE_W +: scmb_pkg::SCORE_W];
         old_in[k]      = req_tdata[OLD_LSB + k*scmb_pkg::SCORE_W +: scmb_pkg::SCORE_W];
      end
   end

   // Stage handshakes
   assign lane_ready = !res_valid_ff || merge_ready;
   assign lane_take  = a_valid_ff && lane_ready;
   assign a_ready    = !a_valid_ff || lane_ready;
   assign req_tready = a_ready;
   assign req_take   = req_tvalid && a_ready;

   // Min stage valid and side payload
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         child_ff <= req_tuser;
         last_ff  <= req_tlast;
         old_ff   <= old_in;
      end
   end

   scmb_min_unit u_min (
      .clock       (clock),
      .load        (req_take),
      .child_score (child_score),
      .best        (best),
      .not_tied    (not_tied)
   );

   // Lane result valid: set when a last request enters the lanes
   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
      end else if (lane_ready) begin
         res_valid_ff <= lane_take && last_ff;
      end
   end

   assign lane_ctrl.take  = lane_take;
   assign lane_ctrl.child = child_ff;
   assign lane_ctrl.last  = last_ff;

   // One accumulator lane per parent nucleotide
   for (genvar g = 0; g < scmb_pkg::NUC_COUNT; g++) begin : g_lane
      scmb_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (lane_ctrl),
         .best      (best),
         .not_tied  (not_tied[g]),
         .old_score (old_ff[g]),
         .res_sum   (lane_sum[g]),
         .res_diff  (lane_diff[g])
      );
   end

   scmb_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (res_valid_ff),
      .in_ready    (merge_ready),
      .lane_sum    (lane_sum),
      .lane_diff   (lane_diff),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_sum     (out_sum),
      .out_changed (rsp_tuser)
   );

   assign rsp_tdata = out_sum;

`ifndef SYNTHESIS
   // At least one lane always reaches the minimum
   a_min_hit: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff |-> (not_tied != '1))
      else $error("min stage marks every lane as above the minimum");

   // A stalled min stage keeps its request
   a_min_hold: assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && !lane_ready) |=> (a_valid_ff && $stable(best) && $stable(last_ff)))
      else $error("min stage lost a request while stalled");

   // A last request entering the lanes yields a lane result
   a_last_result: assert property (@(posedge clock) disable iff (reset)
      (lane_take && last_ff) |=> res_valid_ff)
      else $error("last request produced no lane result");

   // A pending lane result waits unchanged for the merge stage
   a_res_hold: assert property (@(posedge clock) disable iff (reset)
      (res_valid_ff && !merge_ready) |=> (res_valid_ff && $stable(lane_sum)
                                          && $stable(lane_diff)))
      else $error("lane result changed while the merge stage was full");
`endif

endmodule
